// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/fdmd_pkg.sv -----
`timescale 1ns / 1ps

package fdmd_pkg;

  localparam int FRAME_SLOTS  = 4;
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;

  localparam int AREA      = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int PIX_W     = (AREA > 1) ? $clog2(AREA) : 1;
  localparam int HW_W      = $clog2(AREA + 1);
  localparam int SLOT_W    = $clog2(FRAME_SLOTS);
  localparam int MEM_DEPTH = FRAME_SLOTS * AREA;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int                 COUNT_W   = 19;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int MIN_DEFAULT_RAW = (AREA + 19) / 20;
  localparam logic [COUNT_W-1:0] MIN_DEFAULT =
    (MIN_DEFAULT_RAW > (2 ** COUNT_W) - 1) ? COUNT_MAX : COUNT_W'(MIN_DEFAULT_RAW);
  localparam logic [7:0] THRESH_DEFAULT = 8'd25;

  localparam int OUT_DEPTH  = 4;
  localparam int FIFO_PTR_W = $clog2(OUT_DEPTH);
  localparam int FIFO_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam int                    CFG_IDX_W      = 4;
  localparam int                    CFG_DATA_W     = COUNT_W;
  localparam logic [CFG_IDX_W-1:0]  REG_THRESHOLD  = 4'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_MIN_MOTION = 4'd1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W  = OUT_DATA_W - COUNT_W - 2;

  typedef struct packed {
    logic       end_of_frame;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_W-1:0] moving_pixels;
    logic               motion_detected;
    logic               frame_done;
    logic               silhouette;
  } result_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } core_stat_t;

  function automatic logic [7:0] to_gray(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r);
    logic [21:0] sum;
    sum = 22'(b) * 22'd1868 + 22'(g) * 22'd9617 + 22'(r) * 22'd4899 + 22'd8192;
    return sum[21:14];
  endfunction

endpackage

// ----- rtl/fdmd_core.sv -----
`timescale 1ns / 1ps

module fdmd_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_accept,
  input  fdmd_pkg::pixel_t                pix,
  input  logic [7:0]                      thresh,
  input  logic [fdmd_pkg::COUNT_W-1:0]    min_motion_pixels,
  output fdmd_pkg::core_stat_t            stat,
  output logic                            res_valid,
  output fdmd_pkg::result_t               res
);
  import fdmd_pkg::*;

  logic [7:0]        mem [MEM_DEPTH];

  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] oldest_r;
  logic [ADDR_W-1:0] cur_base_r;
  logic [ADDR_W-1:0] old_base_r;
  logic [PIX_W-1:0]  pos_r;
  logic [HW_W-1:0]   cur_hw_r;
  logic [HW_W-1:0]   hw_r [FRAME_SLOTS];

  logic [HW_W-1:0]   pos_ext;
  logic [HW_W-1:0]   pos_inc;
  logic [HW_W-1:0]   hw_upd;
  logic              rd_valid;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              pos_last;
  logic [SLOT_W-1:0] slot_after;
  logic [ADDR_W-1:0] base_after;

  logic              s1_v_r;
  pixel_t            s1_pix_r;
  logic [ADDR_W-1:0] s1_rd_addr_r;
  logic [ADDR_W-1:0] s1_wr_addr_r;
  logic              s1_rd_valid_r;
  logic [7:0]        rdata_r;
  logic [7:0]        s1_gray;
  logic [7:0]        s1_fwd;
  logic [7:0]        s1_prev;

  logic              s2_v_r;
  logic [7:0]        s2_gray_r;
  logic [7:0]        s2_prev_r;
  logic              s2_eof_r;
  logic [ADDR_W-1:0] s2_wr_addr_r;

  logic              lw_v_r;
  logic [ADDR_W-1:0] lw_addr_r;
  logic [7:0]        lw_data_r;

  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] cnt_nxt;
  logic [7:0]         diff;
  logic               silh;

  // Each slot is written in raster order from its first pixel, so the written part of a
  // slot is a prefix whose length is its fill count; pixels past it still read as zero.
  assign pos_ext    = HW_W'(pos_r);
  assign pos_inc    = pos_ext + HW_W'(1);
  assign hw_upd     = (pos_inc > cur_hw_r) ? pos_inc : cur_hw_r;
  assign rd_valid   = pos_ext < hw_r[oldest_r];
  assign wr_addr    = cur_base_r + ADDR_W'(pos_r);
  assign rd_addr    = old_base_r + ADDR_W'(pos_r);
  assign pos_last   = pos_r == PIX_W'(AREA - 1);
  assign slot_after = (oldest_r == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : oldest_r + SLOT_W'(1);
  assign base_after = (old_base_r == ADDR_W'(MEM_DEPTH - AREA)) ? '0
                                                                : old_base_r + ADDR_W'(AREA);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r     <= '0;
      oldest_r   <= SLOT_W'(1);
      cur_base_r <= '0;
      old_base_r <= ADDR_W'(AREA);
      pos_r      <= '0;
      cur_hw_r   <= '0;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        hw_r[i] <= '0;
      end
    end else if (in_accept) begin
      hw_r[slot_r] <= hw_upd;
      if (pix.end_of_frame) begin
        slot_r     <= oldest_r;
        oldest_r   <= slot_after;
        cur_base_r <= old_base_r;
        old_base_r <= base_after;
        pos_r      <= '0;
        cur_hw_r   <= hw_r[oldest_r];
      end else begin
        pos_r    <= pos_last ? '0 : pos_r + PIX_W'(1);
        cur_hw_r <= hw_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      mem[s2_wr_addr_r] <= s2_gray_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      lw_v_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      s1_v_r <= in_accept;
      s2_v_r <= s1_v_r;
      lw_v_r <= s2_v_r;
      if (s2_v_r) begin
        cnt_r <= s2_eof_r ? '0 : cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r      <= pix;
    s1_rd_addr_r  <= rd_addr;
    s1_wr_addr_r  <= wr_addr;
    s1_rd_valid_r <= rd_valid;
    s2_gray_r     <= s1_gray;
    s2_prev_r     <= s1_prev;
    s2_eof_r      <= s1_pix_r.end_of_frame;
    s2_wr_addr_r  <= s1_wr_addr_r;
    lw_addr_r     <= s2_wr_addr_r;
    lw_data_r     <= s2_gray_r;
  end

  // The two writes still ahead of the memory at read time are taken from the pipeline.
  always_comb begin
    s1_gray = to_gray(s1_pix_r.blue, s1_pix_r.green, s1_pix_r.red);
    priority if (s2_v_r && (s2_wr_addr_r == s1_rd_addr_r)) begin
      s1_fwd = s2_gray_r;
    end else if (lw_v_r && (lw_addr_r == s1_rd_addr_r)) begin
      s1_fwd = lw_data_r;
    end else begin
      s1_fwd = rdata_r;
    end
    s1_prev = s1_rd_valid_r ? s1_fwd : 8'd0;
  end

  always_comb begin
    diff    = (s2_gray_r > s2_prev_r) ? s2_gray_r - s2_prev_r : s2_prev_r - s2_gray_r;
    silh    = diff > thresh;
    cnt_nxt = (silh && (cnt_r != COUNT_MAX)) ? cnt_r + COUNT_W'(1) : cnt_r;
    res.silhouette      = silh;
    res.frame_done      = s2_eof_r;
    res.motion_detected = s2_eof_r && (cnt_nxt >= min_motion_pixels);
    res.moving_pixels   = s2_eof_r ? cnt_nxt : '0;
  end

  assign res_valid     = s2_v_r;
  assign stat.s1_valid = s1_v_r;
  assign stat.s2_valid = s2_v_r;

endmodule

// ----- rtl/frame_difference_motion_detector.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake         Contents
// in_       slave      tvalid / tready   one BGR pixel word, tlast on the last pixel
// out_      master     tvalid / tready   one result word per pixel, tlast closes a frame
// cfg_      slave      valid / ready     register index and write data
//
// One pixel word is taken per cycle while in_tready is high; results pass stages s1 and s2.
// Up to four words may be held in the pipeline and the output buffer together, which
// sets how far out_tready may stall before in_tready drops.
// Reset is synchronous and takes effect at once: a per-slot fill count makes pixels
// never written since reset read as zero, so the frame memory needs no clearing pass.
// cfg_ready is always high; the user must write registers only while no pixel is in flight (not enforced).

`include "assert_macros.svh"

module frame_difference_motion_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: blue[7:0], green[15:8], red[23:16].
  input  logic [fdmd_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: silhouette[0], motion_detected[1], moving_pixels[20:2], zeros.
  output logic [fdmd_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fdmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fdmd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fdmd_pkg::*;

  logic [7:0]          thr_r;
  logic [COUNT_W-1:0]  min_r;

  logic                in_accept;
  pixel_t              pix;
  core_stat_t          stat;
  logic                res_valid;
  result_t             res;

  logic [OUT_DATA_W-1:0] fifo_data_r [OUT_DEPTH];
  logic                  fifo_last_r [OUT_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] fifo_cnt_r;
  logic [FIFO_CNT_W-1:0] inflight;
  logic                  push;
  logic                  pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_DEFAULT;
      min_r <= MIN_DEFAULT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD:  thr_r <= cfg_data[7:0];
        REG_MIN_MOTION: min_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_accept        = in_tvalid && in_tready;
  assign pix.blue         = in_tdata[7:0];
  assign pix.green        = in_tdata[15:8];
  assign pix.red          = in_tdata[23:16];
  assign pix.end_of_frame = in_tlast;

  fdmd_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_accept         (in_accept),
    .pix               (pix),
    .thresh            (thr_r),
    .min_motion_pixels (min_r),
    .stat              (stat),
    .res_valid         (res_valid),
    .res               (res)
  );

  // Words in the pipeline are counted against the buffer so that none can be dropped.
  assign inflight = fifo_cnt_r + FIFO_CNT_W'(stat.s1_valid) + FIFO_CNT_W'(stat.s2_valid);
  assign in_tready = inflight < FIFO_CNT_W'(OUT_DEPTH);

  assign push       = res_valid;
  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = fifo_cnt_r != '0;
  assign out_tdata  = fifo_data_r[rd_ptr_r];
  assign out_tlast  = fifo_last_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fifo_cnt_r <= fifo_cnt_r + FIFO_CNT_W'(1);
        2'b01:   fifo_cnt_r <= fifo_cnt_r - FIFO_CNT_W'(1);
        default: fifo_cnt_r <= fifo_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_data_r[wr_ptr_r] <= {OUT_PAD_W'(0), res.moving_pixels, res.motion_detected,
                                res.silhouette};
      fifo_last_r[wr_ptr_r] <= res.frame_done;
    end
  end

  `ASSERT_ALWAYS(a_fifo_bound, clk, rst_n, fifo_cnt_r <= FIFO_CNT_W'(OUT_DEPTH), "output buffer count beyond its depth")
  `ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && !pop && (fifo_cnt_r == FIFO_CNT_W'(OUT_DEPTH))), "result pushed into a full output buffer")
  `ASSERT_IMPLIES(a_midframe_zero, clk, rst_n, out_tvalid && !out_tlast, out_tdata[OUT_DATA_W-1:1] == '0, "frame verdict fields set on a pixel that does not close a frame")
  `ASSERT_IMPLIES(a_ready_credit, clk, rst_n, in_tready, (fifo_cnt_r + FIFO_CNT_W'(stat.s1_valid) + FIFO_CNT_W'(stat.s2_valid)) < FIFO_CNT_W'(OUT_DEPTH), "input ready without room for its result")

endmodule
